// ===== rtl/sirt_pkg.sv =====
// shared types and constants for the signed integer to radix text unit
// no dependencies
package sirt_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned SYM_W      = 8;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned RADIX_W    = 5;
    localparam int unsigned NUM_SLOTS  = 16;
    localparam int unsigned ALPHA_W    = NUM_SLOTS * SYM_W;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned STEP_BITS  = 8;
    localparam int unsigned CHUNKS     = VALUE_W / STEP_BITS;
    localparam int unsigned CHUNK_W    = $clog2(CHUNKS);

    localparam logic [SYM_W-1:0] SIGN_CHAR  = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [SYM_W-1:0] LOW_PRINT  = 8'd32;
    localparam logic [SYM_W-1:0] HIGH_PRINT = 8'd126;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/sirt_ifs.sv =====
// valid/ready channel interfaces: number input, text output, config write
// depends on sirt_pkg
interface sirt_number_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sirt_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirt_text_if;
    logic                        valid;
    logic                        ready;
    logic [sirt_pkg::SYM_W-1:0]  character;
    logic                        final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface sirt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sirt_pkg::CFG_IDX_W-1:0]   index;
    logic [sirt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sirt_alpha_check.sv =====
// alphabet check: radix range, forbidden symbols and repeats among symbols in use
// depends on sirt_pkg
module sirt_alpha_check (
    input  logic [sirt_pkg::ALPHA_W-1:0]  alphabet,
    input  logic [sirt_pkg::RADIX_W-1:0]  radix,
    output logic                          ok
);

    logic [sirt_pkg::SYM_W-1:0]     sym [sirt_pkg::NUM_SLOTS];
    logic [sirt_pkg::NUM_SLOTS-1:0] in_use;
    logic                           bad;

    always_comb
    begin
        for (int a = 0; a < sirt_pkg::NUM_SLOTS; a++)
        begin
            sym[a]    = alphabet[a*sirt_pkg::SYM_W +: sirt_pkg::SYM_W];
            in_use[a] = sirt_pkg::RADIX_W'(a) < radix;
        end
        bad = (radix < sirt_pkg::MIN_RADIX) || (radix > sirt_pkg::MAX_RADIX);
        for (int a = 0; a < sirt_pkg::NUM_SLOTS; a++)
        begin
            if (in_use[a] && (sym[a] == sirt_pkg::PLUS_CHAR || sym[a] == sirt_pkg::SIGN_CHAR
                || sym[a] < sirt_pkg::LOW_PRINT || sym[a] > sirt_pkg::HIGH_PRINT))
            begin
                bad = 1'b1;
            end
            for (int b = a + 1; b < sirt_pkg::NUM_SLOTS; b++)
            begin
                if (in_use[b] && sym[a] == sym[b])
                begin
                    bad = 1'b1;
                end
            end
        end
        ok = !bad;
    end

endmodule

// ===== rtl/sirt_div_step.sv =====
// shared restoring divider slice: eight quotient bits per cycle by a radix up to 16
// depends on sirt_pkg
module sirt_div_step (
    input  logic [sirt_pkg::RADIX_W-1:0]    divisor,
    input  logic [sirt_pkg::DIGIT_W-1:0]    rem_in,
    input  logic [sirt_pkg::STEP_BITS-1:0]  bits_in,
    output logic [sirt_pkg::DIGIT_W-1:0]    rem_out,
    output logic [sirt_pkg::STEP_BITS-1:0]  quot_out
);

    logic [sirt_pkg::RADIX_W-1:0] trial;
    logic [sirt_pkg::DIGIT_W-1:0] rem;

    always_comb
    begin
        rem      = rem_in;
        trial    = '0;
        quot_out = '0;
        for (int i = sirt_pkg::STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, bits_in[i]};
            if (trial >= divisor)
            begin
                quot_out[i] = 1'b1;
                rem         = sirt_pkg::DIGIT_W'(trial - divisor);
            end
            else
            begin
                rem = trial[sirt_pkg::DIGIT_W-1:0];
            end
        end
        rem_out = rem;
    end

endmodule

// ===== rtl/signed_int_to_radix_text_unit.sv =====
// Converts a signed 32-bit number into text in a configured radix of 2 to 16: an optional
// '-' item, then the digits of the magnitude most significant first, the last item marked
// by final_char. One number is handled at a time. Each digit is worked out by the shared
// restoring divider (eight quotient bits per cycle), chunk by chunk from the top of the
// magnitude; the characters are then emitted while the output is taken. With an invalid
// alphabet an item is taken and yields nothing. After a config write the input is held off
// while the alphabet check settles.
// depends on sirt_pkg, sirt_ifs, sirt_alpha_check, sirt_div_step
module signed_int_to_radix_text_unit #(
    parameter int unsigned MAX_DIGITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sirt_cfg_if.sink    cfg,
    sirt_number_if.sink number,
    sirt_text_if.source text
);

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

    sirt_pkg::state_t state_reg, state_next;

    logic [sirt_pkg::CFG_DATA_W-1:0] alpha_low_reg;
    logic [sirt_pkg::CFG_DATA_W-1:0] alpha_high_reg;
    logic [sirt_pkg::RADIX_W-1:0]    radix_reg;
    logic                            ok_reg;
    logic                            dirty_reg;

    logic [sirt_pkg::VALUE_W-1:0]    work_reg;
    logic [sirt_pkg::DIGIT_W-1:0]    rem_reg;
    logic [sirt_pkg::CHUNK_W-1:0]    chunk_reg;
    logic [CNT_W-1:0]                ndig_reg;
    logic [sirt_pkg::DIGIT_W-1:0]    digit_reg [MAX_DIGITS];
    logic [IDX_W-1:0]                k_reg;
    logic                            sign_reg;

    logic                            out_valid_reg;
    logic [sirt_pkg::SYM_W-1:0]      out_char_reg;
    logic                            out_final_reg;

    logic [sirt_pkg::ALPHA_W-1:0]    alphabet;
    logic                            alpha_ok;
    logic [sirt_pkg::DIGIT_W-1:0]    div_rem;
    logic [sirt_pkg::STEP_BITS-1:0]  div_quot;
    logic [sirt_pkg::VALUE_W-1:0]    shifted;
    logic [sirt_pkg::VALUE_W-1:0]    magnitude;
    logic [sirt_pkg::SYM_W-1:0]      cur_sym;
    logic                            last_chunk;
    logic                            div_done;
    logic                            accept;
    logic                            cfg_write;
    logic                            load;
    logic                            last_char;

    assign alphabet = {alpha_high_reg, alpha_low_reg};

    sirt_alpha_check u_check (
        .alphabet (alphabet),
        .radix    (radix_reg),
        .ok       (alpha_ok)
    );

    sirt_div_step u_div (
        .divisor  (radix_reg),
        .rem_in   (rem_reg),
        .bits_in  (work_reg[sirt_pkg::VALUE_W-1 -: sirt_pkg::STEP_BITS]),
        .rem_out  (div_rem),
        .quot_out (div_quot)
    );

    assign shifted    = {work_reg[sirt_pkg::VALUE_W-sirt_pkg::STEP_BITS-1:0], div_quot};
    assign magnitude  = number.value[sirt_pkg::VALUE_W-1] ? (~number.value + 1'b1)
                                                           : number.value;
    assign last_chunk = chunk_reg == sirt_pkg::CHUNK_W'(sirt_pkg::CHUNKS - 1);
    assign div_done   = last_chunk
                        && (shifted == '0 || ndig_reg == CNT_W'(MAX_DIGITS - 1));
    assign cur_sym    = alphabet[{digit_reg[k_reg], 3'b000} +: sirt_pkg::SYM_W];
    assign last_char  = !sign_reg && k_reg == '0;
    assign cfg_write  = cfg.valid && cfg.ready;
    assign accept     = number.valid && number.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sirt_pkg::ST_IDLE:
            begin
                if (accept && ok_reg)
                begin
                    state_next = sirt_pkg::ST_DIVIDE;
                end
            end
            sirt_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = sirt_pkg::ST_EMIT;
                end
            end
            sirt_pkg::ST_EMIT:
            begin
                if (load && last_char)
                begin
                    state_next = sirt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cfg.ready       = 1'b1;
        number.ready    = (state_reg == sirt_pkg::ST_IDLE) && !dirty_reg;
        load            = (state_reg == sirt_pkg::ST_EMIT) && (!out_valid_reg || text.ready);
        text.valid      = out_valid_reg;
        text.character  = out_char_reg;
        text.final_char = out_final_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sirt_pkg::ST_IDLE;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
            ok_reg         <= 1'b0;
            dirty_reg      <= 1'b0;
            chunk_reg      <= '0;
            ndig_reg       <= '0;
            k_reg          <= '0;
            sign_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= alpha_ok;
            dirty_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg.index)
                    sirt_pkg::REG_ALPHA_LOW:  alpha_low_reg  <= cfg.data;
                    sirt_pkg::REG_ALPHA_HIGH: alpha_high_reg <= cfg.data;
                    sirt_pkg::REG_RADIX:      radix_reg      <= cfg.data[sirt_pkg::RADIX_W-1:0];
                    default:                  ;
                endcase
            end
            if (accept && ok_reg)
            begin
                chunk_reg <= '0;
                ndig_reg  <= '0;
                sign_reg  <= number.value[sirt_pkg::VALUE_W-1];
            end
            else if (state_reg == sirt_pkg::ST_DIVIDE)
            begin
                chunk_reg <= chunk_reg + 1'b1;
                if (last_chunk)
                begin
                    ndig_reg <= ndig_reg + 1'b1;
                    k_reg    <= ndig_reg[IDX_W-1:0];
                end
            end
            else if (load)
            begin
                if (sign_reg)
                begin
                    sign_reg <= 1'b0;
                end
                else if (k_reg != '0)
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept && ok_reg)
        begin
            work_reg <= magnitude;
            rem_reg  <= '0;
        end
        else if (state_reg == sirt_pkg::ST_DIVIDE)
        begin
            work_reg <= shifted;
            rem_reg  <= last_chunk ? '0 : div_rem;
            if (last_chunk)
            begin
                digit_reg[ndig_reg[IDX_W-1:0]] <= div_rem;
            end
        end
        if (load)
        begin
            out_char_reg  <= sign_reg ? sirt_pkg::SIGN_CHAR : cur_sym;
            out_final_reg <= last_char;
        end
    end

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sirt_pkg::ST_DIVIDE |-> {1'b0, rem_reg} < radix_reg)
        else $error("divider remainder not below radix");

    a_invalid_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !ok_reg |=> state_reg == sirt_pkg::ST_IDLE)
        else $error("item with invalid alphabet started a conversion");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sirt_pkg::ST_EMIT |-> ndig_reg != '0)
        else $error("emitting with no digits stored");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_final_reg |-> out_char_reg != sirt_pkg::SIGN_CHAR)
        else $error("sign marked as last character");
`endif

endmodule
